// ----- rtl/core/lkc_pkg.sv -----
// Shared constants and types for the LRU key cache.
`default_nettype none
package lkc_pkg;

    localparam int KEY_W       = 8;
    localparam int VALUE_W     = 9;
    localparam int CAP_CFG_W   = 5;
    localparam int LIMIT_W     = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    localparam int KEY_SPACE        = 256;
    localparam int CAPACITY_DEFAULT = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT = 1'b1;

    localparam logic [CAP_CFG_W-1:0] CAPACITY_RESET  = 5'd16;
    localparam logic [LIMIT_W-1:0]   KEY_LIMIT_RESET = 9'd256;

    // Control broadcast from the top level to every cell of the recency chain.
    typedef struct packed {
        logic en;     // a valid, in-range item is being applied this cycle
        logic hit;    // the item's key is resident somewhere in the chain
        logic evict;  // miss with the list full: the last valid entry drops out
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/core/lkc_cell.sv -----
// One entry of the recency chain: a key register, its valid bit and the neighbor links.
`default_nettype none
module lkc_cell
    import lkc_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_cell_ctl   i_ctl,
    input  wire [KEY_W-1:0]  i_key,
    input  wire [KEY_W-1:0]  i_prev_key,
    input  wire              i_prev_valid,
    input  wire              i_next_valid,
    input  wire              i_match_after,
    input  wire [KEY_W-1:0]  i_victim,
    output logic [KEY_W-1:0] o_key,
    output logic             o_valid,
    output logic             o_match_ge,
    output logic [KEY_W-1:0] o_victim
);

    logic [KEY_W-1:0] r_key;
    logic             r_valid;
    logic             w_match;
    logic             w_load;

    assign w_match    = r_valid && (r_key == i_key);
    assign o_match_ge = w_match || i_match_after;

    // An entry takes its front neighbor's key when it lies between the front
    // and the position being vacated: the hit entry, the evicted entry, or
    // the first free entry.
    always_comb begin
        if (i_ctl.hit) begin
            w_load = i_ctl.en && o_match_ge;
        end else if (i_ctl.evict) begin
            w_load = i_ctl.en && r_valid;
        end else begin
            w_load = i_ctl.en && i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en && !i_ctl.hit && !i_ctl.evict) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key    = r_key;
    assign o_valid  = r_valid;
    assign o_victim = i_victim | ((r_valid && !i_next_valid) ? r_key : '0);

endmodule
`default_nettype wire

// ----- rtl/core/lru_key_cache_unit.sv -----
// Top level of the LRU key cache: configuration, cell chain and result register.
//
// The cache takes one key per cycle: an item is accepted whenever start is
// high (busy never rises) and its result appears on the o_ ports in the
// next cycle, marked by o_done for that single cycle. The recency list is a row of
// CAPACITY cells, entry 0 the most recent; every cell compares its key with
// the incoming one in parallel and the move-to-front is one shift along the
// row, so the state is fully updated at the edge that accepts the item. The
// longest path is the match chain across all cells feeding the shift enables.
// No clearing pass is needed after reset. Configuration writes take effect
// at the edge that carries them.
`default_nettype none
module lru_key_cache_unit
    import lkc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire [KEY_W-1:0]       i_key,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                  o_done,
    output logic                  o_hit,
    output logic [VALUE_W-1:0]    o_value,
    output logic                  o_evicted_valid,
    output logic [KEY_W-1:0]      o_evicted_key,
    output logic                  o_range_error
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = 13;

    logic [CAP_CFG_W-1:0] r_capacity;
    logic [LIMIT_W-1:0]   r_key_limit;

    logic [KEY_W-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY:0]   w_mge;
    logic [KEY_W-1:0] w_vic [CAPACITY+1];

    logic             w_accept;
    logic             w_err;
    logic             w_hit;
    logic             w_evict;
    logic [IDX_W-1:0] w_cap_idx;
    logic [6:0]       w_cap;
    t_cell_ctl        w_ctl;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RESET;
            r_key_limit <= KEY_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAPACITY:  r_capacity  <= i_cfg_data[CAP_CFG_W-1:0];
                REG_KEY_LIMIT: r_key_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // A capacity of zero acts as one, and one above the cell count as the cell count.
    assign w_cap = 7'(r_capacity);
    always_comb begin
        if (w_cap == 7'd0) begin
            w_cap_idx = '0;
        end else if (w_cap > 7'(CAPACITY)) begin
            w_cap_idx = IDX_W'(CAPACITY - 1);
        end else begin
            w_cap_idx = IDX_W'(w_cap - 7'd1);
        end
    end

    assign w_err = ({1'b0, i_key} >= r_key_limit) ||
                   (CMP_W'(i_key) >= CMP_W'(KEY_SPACE));
    assign w_hit   = w_mge[0];
    // The valid bits form a prefix, so the list is full exactly when the
    // entry at the effective capacity minus one holds a key.
    assign w_evict = !w_hit && w_valid[w_cap_idx];

    assign w_ctl.en    = w_accept && !w_err;
    assign w_ctl.hit   = w_hit;
    assign w_ctl.evict = w_evict;

    assign w_mge[CAPACITY] = 1'b0;
    assign w_vic[0]        = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_prev_key;
        logic             w_prev_valid;
        logic             w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_key   = i_key;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_key   = w_cell_key[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
        end

        lkc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_key         (i_key),
            .i_prev_key    (w_prev_key),
            .i_prev_valid  (w_prev_valid),
            .i_next_valid  (w_next_valid),
            .i_match_after (w_mge[g+1]),
            .i_victim      (w_vic[g]),
            .o_key         (w_cell_key[g]),
            .o_valid       (w_valid[g]),
            .o_match_ge    (w_mge[g]),
            .o_victim      (w_vic[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_range_error   <= w_err;
            o_hit           <= !w_err && w_hit;
            o_value         <= w_err ? '0 : VALUE_W'({1'b0, i_key} + 9'd1);
            o_evicted_valid <= !w_err && w_evict;
            o_evicted_key   <= (!w_err && w_evict) ? w_vic[CAPACITY] : '0;
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted item produced no result");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_evicted_valid))
        else $error("hit reported together with an eviction");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_range_error) |-> (!o_hit && !o_evicted_valid && o_value == '0))
        else $error("range error result carries other fields");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("valid entries do not form a prefix of the chain");

    a_front_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.en |=> (w_valid[0] && w_cell_key[0] == $past(i_key)))
        else $error("referenced key is not at the most recent position");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the LRU key cache: directed and random key references.
module testbench;
    import lkc_pkg::*;

    localparam int SLOTS       = CAPACITY_DEFAULT;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] value;
        logic               evicted_valid;
        logic [KEY_W-1:0]   evicted_key;
        logic               range_error;
    } t_lookup;

    // Tracks the cache contents and holds the lookups still owed by the block.
    class lookup_board;
        bit [KEY_W-1:0]     order[SLOTS];
        int unsigned        fill;
        bit                 resident[KEY_SPACE];
        bit [CAP_CFG_W-1:0] cap_reg;
        bit [LIMIT_W-1:0]   limit_reg;
        t_lookup            expected_lookups[$];
        int unsigned        mismatches;

        function new();
            cap_reg = CAPACITY_RESET;
            limit_reg = KEY_LIMIT_RESET;
            fill = 0;
            mismatches = 0;
            foreach (resident[i]) resident[i] = 1'b0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == REG_CAPACITY) begin
                cap_reg = data[CAP_CFG_W-1:0];
            end else begin
                limit_reg = data[LIMIT_W-1:0];
            end
        endfunction

        function int unsigned effective_capacity();
            if (cap_reg == 0) return 1;
            if (cap_reg > SLOTS) return SLOTS;
            return cap_reg;
        endfunction

        function void note_reference(bit [KEY_W-1:0] key);
            t_lookup     want;
            int unsigned pos;
            bit [KEY_W-1:0] victim;
            want = '0;
            if (key >= limit_reg) begin
                want.range_error = 1'b1;
                expected_lookups.push_back(want);
                return;
            end
            if (resident[key]) begin
                pos = 0;
                while (pos + 1 < fill && order[pos] != key) pos++;
                want.hit = 1'b1;
            end else begin
                // With the capacity lowered below the fill level, only one key leaves.
                if (fill >= effective_capacity()) begin
                    victim = order[fill-1];
                    resident[victim] = 1'b0;
                    want.evicted_valid = 1'b1;
                    want.evicted_key = victim;
                    fill--;
                end
                pos = fill;
                fill++;
                resident[key] = 1'b1;
            end
            for (; pos > 0; pos--) order[pos] = order[pos-1];
            order[0] = key;
            want.value = {1'b0, key} + 9'd1;
            expected_lookups.push_back(want);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("lookup check failed: %s got %0d expected %0d at %0t",
                     what, got, want, $time);
            mismatches++;
        endtask

        task check_lookup(t_lookup got);
            t_lookup want;
            if (expected_lookups.size() == 0) begin
                report_mismatch("result with no item pending", 1, 0);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.hit != want.hit)
                report_mismatch("hit", got.hit, want.hit);
            if (got.value != want.value)
                report_mismatch("value", got.value, want.value);
            if (got.evicted_valid != want.evicted_valid)
                report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
            if (got.evicted_key != want.evicted_key)
                report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
            if (got.range_error != want.range_error)
                report_mismatch("range_error", got.range_error, want.range_error);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [KEY_W-1:0]      i_key = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_CAPACITY;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_done;
    logic                  o_hit;
    logic [VALUE_W-1:0]    o_value;
    logic                  o_evicted_valid;
    logic [KEY_W-1:0]      o_evicted_key;
    logic                  o_range_error;

    lookup_board board = new();

    lru_key_cache_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_key           (i_key),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_value         (o_value),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_range_error   (o_range_error)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Everything is sampled at the edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                board.check_lookup({o_hit, o_value, o_evicted_valid, o_evicted_key,
                                    o_range_error});
            if (i_cfg_we)
                board.set_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                board.note_reference(i_key);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done || i_cfg_we) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_key(input logic [KEY_W-1:0] key);
        start <= 1'b1;
        i_key <= key;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every owed lookup has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.expected_lookups.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes both registers; the capacity write carries random upper data bits.
    task automatic configure(input logic [CAP_CFG_W-1:0] cap,
                             input logic [LIMIT_W-1:0] limit);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_CAPACITY;
        i_cfg_data <= {4'($urandom_range(0, 15)), cap};
        @(posedge i_clk);
        i_cfg_idx <= REG_KEY_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly references to a working set near the capacity, so hits and
    // evictions both happen, with full-range keys and rejected keys mixed in.
    task automatic run_phase(input int count, input bit gaps);
        logic [KEY_W-1:0] base;
        int unsigned      pool;
        int unsigned      r;
        logic [KEY_W-1:0] key;
        base = KEY_W'($urandom);
        pool = board.effective_capacity() + $urandom_range(0, 4);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                key = base + KEY_W'($urandom_range(0, pool - 1));
            else if (r < 90 || board.limit_reg >= KEY_SPACE)
                key = KEY_W'($urandom);
            else
                key = KEY_W'($urandom_range(board.limit_reg, KEY_SPACE - 1));
            send_key(key);
            if (gaps && $urandom_range(0, 9) < 3)
                pause($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                               : $urandom_range(10, 40));
        end
        drain();
    endtask

    initial begin : stimulus
        logic [CAP_CFG_W-1:0] cap;
        logic [LIMIT_W-1:0]   limit;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default setup: extremes, a hit, a full list, then a hit on the full list.
        send_key(8'd0);
        send_key(8'd255);
        send_key(8'd0);
        for (int k = 1; k <= 13; k++) send_key(KEY_W'(k));
        send_key(8'd200);
        send_key(8'd255);
        drain();

        // Capacity dropped below the fill level, limit in the middle.
        configure(5'd4, 9'd100);
        send_key(8'd150);
        send_key(8'd99);
        send_key(8'd100);
        send_key(8'd5);
        drain();

        // Zero capacity acts as one; a zero limit rejects everything.
        configure(5'd0, 9'd0);
        send_key(8'd0);
        send_key(8'd255);
        drain();

        // Capacity beyond the list size is clamped; widest limit.
        configure(5'd31, 9'd511);
        send_key(8'd77);
        drain();

        configure(5'd1, 9'd256);
        run_phase(80, 1'b1);
        configure(5'd16, 9'd256);
        run_phase(80, 1'b0);
        configure(5'd0, 9'd511);
        run_phase(80, 1'b1);
        configure(5'd31, 9'd0);
        run_phase(20, 1'b1);
        configure(5'd5, 9'd1);
        run_phase(20, 1'b0);
        for (int p = 0; p < 4; p++) begin
            cap = CAP_CFG_W'($urandom_range(0, 31));
            limit = $urandom_range(0, 1) ? LIMIT_W'($urandom_range(256, 511))
                                         : LIMIT_W'($urandom_range(1, 255));
            configure(cap, limit);
            run_phase(90, p != 2);
        end

        if (board.mismatches == 0 && board.expected_lookups.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/lkc_pkg.sv
rtl/core/lkc_cell.sv
rtl/core/lru_key_cache_unit.sv
sim/testbench.sv
